FILE: src/clipped_sprite_blitter_macros.svh
`ifndef CLIPPED_SPRITE_BLITTER_MACROS_SVH
`define CLIPPED_SPRITE_BLITTER_MACROS_SVH

`ifndef SYNTHESIS

`define CSB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define CSB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CSB_ASSERT_IMP(lbl, ante, cons, msg)

`define CSB_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

FILE: src/csb_pkg.sv
package csb_pkg;

    localparam int CW = 13;
    localparam int PIX_W = 8;
    localparam int TABLE_AW = 16;

    localparam logic [1:0] REQ_PIXEL = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_LOAD  = 2'd2;

    localparam logic [1:0] MODE_OPAQUE    = 2'd0;
    localparam logic [1:0] MODE_KEY       = 2'd1;
    localparam logic [1:0] MODE_BLEND_SRC = 2'd2;
    localparam logic [1:0] MODE_BLEND_DST = 2'd3;

    typedef enum logic [2:0] {
        OP_WRITE,
        OP_BLEND,
        OP_READ,
        OP_READ_ZERO,
        OP_LOAD
    } op_kind_t;

    typedef struct packed {
        op_kind_t         kind;
        logic             dst_major;
        logic [PIX_W-1:0] data;
    } csb_op_t;

endpackage

FILE: src/csb_ram.sv
module csb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: src/csb_front.sv
module csb_front
    import csb_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 200,
    parameter int COORD_OFFSET  = 16,
    parameter int FAW           = 16,
    parameter int AW            = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic                 cfg_write_data,
    input  logic                 item_accept,
    input  logic [1:0]           req_type,
    input  logic                 first_pixel,
    input  logic signed [10:0]   origin_x,
    input  logic signed [10:0]   origin_y,
    input  logic [8:0]           sprite_w,
    input  logic [8:0]           sprite_h,
    input  logic [1:0]           blit_mode,
    input  logic [7:0]           src_pixel,
    input  logic [15:0]          address,
    input  logic [7:0]           table_data,
    output logic                 op_valid,
    output csb_op_t              op,
    output logic [AW-1:0]        op_addr
);

    localparam int XW = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
    localparam int YW = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
    localparam logic signed [CW-1:0] OFS_S = CW'(COORD_OFFSET);
    localparam logic signed [CW-1:0] SW_S  = CW'(SCREEN_WIDTH);
    localparam logic signed [CW-1:0] SH_S  = CW'(SCREEN_HEIGHT);
    localparam logic [AW:0] FRAME_LIM = (AW+1)'(SCREEN_WIDTH * SCREEN_HEIGHT);

    logic [8:0] col_reg, col_next;
    logic [8:0] row_reg, row_next;
    logic       draw_en_reg, draw_en_next;

    logic [8:0]           col_base, row_base;
    logic [9:0]           col_inc;
    logic signed [CW-1:0] dx, dy;
    logic                 in_screen, draw, src_nz, in_frame;
    logic [FAW-1:0]       pix_addr;

    always_comb
    begin
        col_base  = first_pixel ? 9'd0 : col_reg;
        row_base  = first_pixel ? 9'd0 : row_reg;
        col_inc   = {1'b0, col_base} + 10'd1;
        dx        = CW'(origin_x) - OFS_S + $signed({4'b0000, col_base});
        dy        = CW'(origin_y) - OFS_S + $signed({4'b0000, row_base});
        in_screen = !dx[CW-1] && (dx < SW_S) && !dy[CW-1] && (dy < SH_S);
        draw      = draw_en_reg && (col_base < sprite_w) && (row_base < sprite_h)
                    && in_screen;
        src_nz    = src_pixel != 8'd0;
        pix_addr  = FAW'(dy[YW-1:0]) * FAW'(SCREEN_WIDTH) + FAW'(dx[XW-1:0]);
        in_frame  = {1'b0, AW'(address)} < FRAME_LIM;

        op_valid     = 1'b0;
        op.kind      = OP_WRITE;
        op.dst_major = blit_mode == MODE_BLEND_DST;
        op.data      = src_pixel;
        op_addr      = AW'(pix_addr);
        case (req_type)
            REQ_PIXEL:
            begin
                if (draw)
                begin
                    if (blit_mode == MODE_OPAQUE || (blit_mode == MODE_KEY && src_nz))
                    begin
                        op_valid = 1'b1;
                    end
                    else if ((blit_mode == MODE_BLEND_SRC || blit_mode == MODE_BLEND_DST)
                             && src_nz)
                    begin
                        op_valid = 1'b1;
                        op.kind  = OP_BLEND;
                    end
                end
            end
            REQ_READ:
            begin
                op_valid = 1'b1;
                op.kind  = in_frame ? OP_READ : OP_READ_ZERO;
                op_addr  = AW'(address);
            end
            REQ_LOAD:
            begin
                op_valid = 1'b1;
                op.kind  = OP_LOAD;
                op.data  = table_data;
                op_addr  = AW'(address);
            end
            default:
            begin
                op_valid = 1'b0;
            end
        endcase

        col_next     = col_reg;
        row_next     = row_reg;
        draw_en_next = cfg_write_en ? cfg_write_data : draw_en_reg;
        if (item_accept && req_type == REQ_PIXEL)
        begin
            if (col_inc >= {1'b0, sprite_w})
            begin
                col_next = 9'd0;
                row_next = row_base + 9'd1;
            end
            else
            begin
                col_next = col_inc[8:0];
                row_next = row_base;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            draw_en_reg <= 1'b1;
        end
        else
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            draw_en_reg <= draw_en_next;
        end
    end

endmodule

FILE: src/csb_queue.sv
module csb_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] dout
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entries [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    cnt_reg, cnt_next;

    assign full  = cnt_reg == NW'(DEPTH);
    assign valid = cnt_reg != '0;
    assign dout  = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + NW'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= din;
        end
    end

endmodule

FILE: src/csb_back.sv
module csb_back
    import csb_pkg::*;
#(
    parameter int FRAME_SIZE = 64000,
    parameter int FAW        = 16,
    parameter int AW         = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  csb_op_t       q_op,
    input  logic [AW-1:0] q_addr,
    output logic          q_pop,
    output logic          clearing,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    read_data
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_RUN,
        ST_BLEND_TBL,
        ST_BLEND_WR
    } state_t;

    localparam logic [FAW-1:0] LAST_ADDR = FAW'(FRAME_SIZE - 1);

    state_t               state_reg, state_next;
    logic [FAW-1:0]       clr_addr_reg, clr_addr_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic                 rd_zero_reg, rd_zero_next;
    logic [FAW-1:0]       baddr_reg, baddr_next;
    logic [PIX_W-1:0]     bsrc_reg, bsrc_next;
    logic                 bdst_reg, bdst_next;
    logic [1:0]           ocnt_reg, ocnt_next;
    logic [PIX_W-1:0]     slot0_reg, slot0_next;
    logic [PIX_W-1:0]     slot1_reg, slot1_next;

    logic                 fb_we, fb_re;
    logic [FAW-1:0]       fb_waddr, fb_raddr;
    logic [PIX_W-1:0]     fb_wdata, fb_rdata;
    logic                 tb_we, tb_re;
    logic [TABLE_AW-1:0]  tb_waddr, tb_raddr;
    logic [PIX_W-1:0]     tb_wdata, tb_rdata;
    logic                 out_pop, rd_room;
    logic [PIX_W-1:0]     push_data;

    csb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (FRAME_SIZE)
    ) u_frame (
        .clk   (clk),
        .we    (fb_we),
        .waddr (fb_waddr),
        .wdata (fb_wdata),
        .re    (fb_re),
        .raddr (fb_raddr),
        .rdata (fb_rdata)
    );

    csb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (1 << TABLE_AW)
    ) u_table (
        .clk   (clk),
        .we    (tb_we),
        .waddr (tb_waddr),
        .wdata (tb_wdata),
        .re    (tb_re),
        .raddr (tb_raddr),
        .rdata (tb_rdata)
    );

    assign clearing  = state_reg == ST_CLEAR;
    assign out_valid = ocnt_reg != 2'd0;
    assign read_data = slot0_reg;

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        rd_pend_next  = 1'b0;
        rd_zero_next  = rd_zero_reg;
        baddr_next    = baddr_reg;
        bsrc_next     = bsrc_reg;
        bdst_next     = bdst_reg;

        fb_we    = 1'b0;
        fb_waddr = q_addr[FAW-1:0];
        fb_wdata = q_op.data;
        fb_re    = 1'b0;
        fb_raddr = q_addr[FAW-1:0];
        tb_we    = 1'b0;
        tb_waddr = q_addr[TABLE_AW-1:0];
        tb_wdata = q_op.data;
        tb_re    = 1'b0;
        tb_raddr = bdst_reg ? {fb_rdata, bsrc_reg} : {bsrc_reg, fb_rdata};
        q_pop    = 1'b0;

        out_pop = out_valid && out_ready;
        rd_room = (({1'b0, ocnt_reg} + {2'b00, rd_pend_reg}) - {2'b00, out_pop}) < 3'd2;

        case (state_reg)
            ST_CLEAR:
            begin
                fb_we    = 1'b1;
                fb_waddr = clr_addr_reg;
                fb_wdata = '0;
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_RUN;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + FAW'(1);
                end
            end
            ST_RUN:
            begin
                if (q_valid)
                begin
                    case (q_op.kind)
                        OP_WRITE:
                        begin
                            fb_we = 1'b1;
                            q_pop = 1'b1;
                        end
                        OP_BLEND:
                        begin
                            fb_re      = 1'b1;
                            q_pop      = 1'b1;
                            baddr_next = q_addr[FAW-1:0];
                            bsrc_next  = q_op.data;
                            bdst_next  = q_op.dst_major;
                            state_next = ST_BLEND_TBL;
                        end
                        OP_READ:
                        begin
                            if (rd_room)
                            begin
                                fb_re        = 1'b1;
                                q_pop        = 1'b1;
                                rd_pend_next = 1'b1;
                                rd_zero_next = 1'b0;
                            end
                        end
                        OP_READ_ZERO:
                        begin
                            if (rd_room)
                            begin
                                q_pop        = 1'b1;
                                rd_pend_next = 1'b1;
                                rd_zero_next = 1'b1;
                            end
                        end
                        OP_LOAD:
                        begin
                            tb_we = 1'b1;
                            q_pop = 1'b1;
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_BLEND_TBL:
            begin
                tb_re      = 1'b1;
                state_next = ST_BLEND_WR;
            end
            ST_BLEND_WR:
            begin
                fb_we      = 1'b1;
                fb_waddr   = baddr_reg;
                fb_wdata   = tb_rdata;
                state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase

        // two-entry result buffer
        push_data  = rd_zero_reg ? '0 : fb_rdata;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        ocnt_next  = ocnt_reg;
        if (out_pop)
        begin
            slot0_next = slot1_reg;
            ocnt_next  = ocnt_reg - 2'd1;
        end
        if (rd_pend_reg)
        begin
            if (ocnt_next == 2'd0)
            begin
                slot0_next = push_data;
            end
            else
            begin
                slot1_next = push_data;
            end
            ocnt_next = ocnt_next + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            rd_pend_reg  <= 1'b0;
            rd_zero_reg  <= 1'b0;
            baddr_reg    <= '0;
            bsrc_reg     <= '0;
            bdst_reg     <= 1'b0;
            ocnt_reg     <= 2'd0;
            slot0_reg    <= '0;
            slot1_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            rd_pend_reg  <= rd_pend_next;
            rd_zero_reg  <= rd_zero_next;
            baddr_reg    <= baddr_next;
            bsrc_reg     <= bsrc_next;
            bdst_reg     <= bdst_next;
            ocnt_reg     <= ocnt_next;
            slot0_reg    <= slot0_next;
            slot1_reg    <= slot1_next;
        end
    end

endmodule

FILE: src/clipped_sprite_blitter.sv
// channel   direction  handshake               payload
// in        input      in_valid / in_ready     req_type .. table_data
// out       output     out_valid / out_ready   read_data
// cfg       input      cfg_write_en            cfg_write_data (draw enable)
//
// one item per cycle enters the front and its queue while in_ready is high
// the back engine takes one item per cycle while reads find room; a blend
// pixel holds it (frame store read, blend table read, frame store write)
// read results pass the frame store register, then the result buffer
// after reset the SCREEN_WIDTH*SCREEN_HEIGHT frame store bytes are cleared
// (64000 by default), with in_ready low
`include "clipped_sprite_blitter_macros.svh"

module clipped_sprite_blitter
    import csb_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 200,
    parameter int COORD_OFFSET  = 16,
    parameter int QUEUE_DEPTH   = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic               cfg_write_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         req_type,
    input  logic               first_pixel,
    input  logic signed [10:0] origin_x,
    input  logic signed [10:0] origin_y,
    input  logic [8:0]         sprite_w,
    input  logic [8:0]         sprite_h,
    input  logic [1:0]         blit_mode,
    input  logic [7:0]         src_pixel,
    input  logic [15:0]        address,
    input  logic [7:0]         table_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         read_data
);

    localparam int FRAME_SIZE = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int FAW = $clog2(FRAME_SIZE);
    localparam int AW  = (FAW > TABLE_AW) ? FAW : TABLE_AW;
    localparam int QW  = $bits(csb_op_t) + AW;
    localparam logic [AW:0] FRAME_LIM = (AW+1)'(FRAME_SIZE);

    logic          item_accept, push, q_full, q_valid, q_pop, clearing;
    logic          op_valid, op_addr_ok, write_push;
    csb_op_t       op, q_op;
    logic [AW-1:0] op_addr, q_addr;
    logic [QW-1:0] q_dout;

    assign in_ready    = !clearing && !q_full;
    assign item_accept = in_valid && in_ready;
    assign push        = item_accept && op_valid;
    assign {q_op, q_addr} = q_dout;

    csb_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .COORD_OFFSET  (COORD_OFFSET),
        .FAW           (FAW),
        .AW            (AW)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .item_accept    (item_accept),
        .req_type       (req_type),
        .first_pixel    (first_pixel),
        .origin_x       (origin_x),
        .origin_y       (origin_y),
        .sprite_w       (sprite_w),
        .sprite_h       (sprite_h),
        .blit_mode      (blit_mode),
        .src_pixel      (src_pixel),
        .address        (address),
        .table_data     (table_data),
        .op_valid       (op_valid),
        .op             (op),
        .op_addr        (op_addr)
    );

    csb_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   ({op, op_addr}),
        .full  (q_full),
        .pop   (q_pop),
        .valid (q_valid),
        .dout  (q_dout)
    );

    csb_back #(
        .FRAME_SIZE (FRAME_SIZE),
        .FAW        (FAW),
        .AW         (AW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_op      (q_op),
        .q_addr    (q_addr),
        .q_pop     (q_pop),
        .clearing  (clearing),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .read_data (read_data)
    );

    assign op_addr_ok = {1'b0, op_addr} < FRAME_LIM;
    assign write_push = push && (op.kind == OP_WRITE || op.kind == OP_BLEND);

    `CSB_ASSERT_NXT(a_clear_once, !clearing, !clearing, "clear pass restarted")
    `CSB_ASSERT_IMP(a_pop_valid, q_pop, q_valid, "queue popped while empty")
    `CSB_ASSERT_IMP(a_no_pop_clear, clearing, !q_pop, "queue popped during clear pass")
    `CSB_ASSERT_IMP(a_pix_addr, write_push, op_addr_ok, "pixel address beyond frame")

endmodule

FILE: test/csb_tb_pkg.sv
package csb_tb_pkg;
    import csb_pkg::*;

    localparam int SCREEN_W    = 320;
    localparam int SCREEN_H    = 200;
    localparam int ORIGIN_BIAS = 16;
    localparam int FRAME_BYTES = SCREEN_W * SCREEN_H;

    localparam logic [1:0] REQ_NONE = 2'd3;

    typedef struct {
        logic [1:0]         req_type;
        logic               first_pixel;
        logic signed [10:0] origin_x;
        logic signed [10:0] origin_y;
        logic [8:0]         sprite_w;
        logic [8:0]         sprite_h;
        logic [1:0]         blit_mode;
        logic [7:0]         src_pixel;
        logic [15:0]        address;
        logic [7:0]         table_data;
    } blit_item_t;

    class frame_shadow;
        logic [7:0] frame_bytes [FRAME_BYTES];
        logic [7:0] blend_entries [65536];
        bit         blend_loaded [65536];
        int         col;
        int         row;
        bit         draw_on;
        logic [7:0] expected_reads [$];
        int         errors;
        int         checked;
        int         landed;

        function new();
            foreach (frame_bytes[i])
                frame_bytes[i] = 8'd0;
            foreach (blend_entries[i])
                blend_entries[i] = 8'd0;
            col = 0;
            row = 0;
            draw_on = 1'b1;
            errors = 0;
            checked = 0;
            landed = 0;
        endfunction

        // screen byte a sprite pixel would land on, if any
        function bit pixel_target(blit_item_t it, output int unsigned addr);
            int c;
            int r;
            int sx;
            int sy;
            int dx;
            int dy;
            c = it.first_pixel ? 0 : col;
            r = it.first_pixel ? 0 : row;
            sx = int'(it.origin_x);
            sy = int'(it.origin_y);
            dx = sx - ORIGIN_BIAS + c;
            dy = sy - ORIGIN_BIAS + r;
            addr = 0;
            if (!draw_on || c >= int'(it.sprite_w) || r >= int'(it.sprite_h))
                return 1'b0;
            if (dx < 0 || dx >= SCREEN_W || dy < 0 || dy >= SCREEN_H)
                return 1'b0;
            addr = dy * SCREEN_W + dx;
            return 1'b1;
        endfunction

        // blend table entry a sprite pixel would fetch, if any
        function bit blend_slot(blit_item_t it, output logic [15:0] idx);
            int unsigned a;
            logic [7:0]  dst;
            idx = 16'd0;
            if (it.blit_mode != MODE_BLEND_SRC && it.blit_mode != MODE_BLEND_DST)
                return 1'b0;
            if (it.src_pixel == 8'd0 || !pixel_target(it, a))
                return 1'b0;
            dst = frame_bytes[a];
            idx = (it.blit_mode == MODE_BLEND_SRC) ? {it.src_pixel, dst} : {dst, it.src_pixel};
            return 1'b1;
        endfunction

        function void note_item(blit_item_t it);
            int unsigned a;
            logic [15:0] idx;
            case (it.req_type)
                REQ_PIXEL:
                begin
                    if (pixel_target(it, a))
                    begin
                        if (blend_slot(it, idx))
                        begin
                            frame_bytes[a] = blend_entries[idx];
                            landed++;
                        end
                        else if (it.blit_mode == MODE_OPAQUE ||
                                 (it.blit_mode == MODE_KEY && it.src_pixel != 8'd0))
                        begin
                            frame_bytes[a] = it.src_pixel;
                            landed++;
                        end
                    end
                    if (it.first_pixel)
                    begin
                        col = 0;
                        row = 0;
                    end
                    if (col + 1 >= int'(it.sprite_w))
                    begin
                        col = 0;
                        row = (row + 1) % 512;
                    end
                    else
                        col = col + 1;
                end
                REQ_READ:
                    expected_reads.push_back((int'(it.address) < FRAME_BYTES) ?
                                             frame_bytes[it.address] : 8'd0);
                REQ_LOAD:
                begin
                    blend_entries[it.address] = it.table_data;
                    blend_loaded[it.address] = 1'b1;
                end
                default:
                    ;
            endcase
        endfunction

        function void check_read(logic [7:0] got, realtime stamp);
            logic [7:0] want;
            if (expected_reads.size() == 0)
            begin
                errors++;
                $display("%0.1f ns: read_data expected none, got %02h", stamp, got);
                return;
            end
            want = expected_reads.pop_front();
            checked++;
            if (got !== want)
            begin
                errors++;
                $display("%0.1f ns: read_data expected %02h, got %02h", stamp, want, got);
            end
        endfunction

        function int pending();
            return expected_reads.size();
        endfunction
    endclass
endpackage

FILE: test/clipped_sprite_blitter_tb.sv
module clipped_sprite_blitter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import csb_pkg::*;
    import csb_tb_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 64;
    localparam int STALL_LIMIT  = 200000;
    localparam int ITEM_TARGET  = 1150;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_write_en = 1'b0;
    logic               cfg_write_data = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         req_type = REQ_PIXEL;
    logic               first_pixel = 1'b0;
    logic signed [10:0] origin_x = '0;
    logic signed [10:0] origin_y = '0;
    logic [8:0]         sprite_w = '0;
    logic [8:0]         sprite_h = '0;
    logic [1:0]         blit_mode = MODE_OPAQUE;
    logic [7:0]         src_pixel = '0;
    logic [15:0]        address = '0;
    logic [7:0]         table_data = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [7:0]         read_data;

    frame_shadow shadow = new();
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    bit          start_hold = 1'b0;
    int          items_sent = 0;

    always #1 clk = ~clk;

    clipped_sprite_blitter #(
        .SCREEN_WIDTH  (SCREEN_W),
        .SCREEN_HEIGHT (SCREEN_H),
        .COORD_OFFSET  (ORIGIN_BIAS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .first_pixel    (first_pixel),
        .origin_x       (origin_x),
        .origin_y       (origin_y),
        .sprite_w       (sprite_w),
        .sprite_h       (sprite_h),
        .blit_mode      (blit_mode),
        .src_pixel      (src_pixel),
        .address        (address),
        .table_data     (table_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .read_data      (read_data)
    );

    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                shadow.check_read(read_data, $realtime);
            if (start_hold)
            begin
                start_hold = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0.1f ns: no item moved for %0d cycles", $realtime, STALL_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    function automatic blit_item_t noise_item();
        blit_item_t it;
        it.req_type    = 2'($urandom);
        it.first_pixel = 1'($urandom);
        it.origin_x    = 11'($urandom);
        it.origin_y    = 11'($urandom);
        it.sprite_w    = 9'($urandom);
        it.sprite_h    = 9'($urandom);
        it.blit_mode   = 2'($urandom);
        it.src_pixel   = 8'($urandom);
        it.address     = 16'($urandom);
        it.table_data  = 8'($urandom);
        return it;
    endfunction

    function automatic blit_item_t pixel_item(bit first, int ox, int oy, int w, int h,
                                              logic [1:0] mode, logic [7:0] src);
        blit_item_t it;
        it = noise_item();
        it.req_type    = REQ_PIXEL;
        it.first_pixel = first;
        it.origin_x    = 11'(ox);
        it.origin_y    = 11'(oy);
        it.sprite_w    = 9'(w);
        it.sprite_h    = 9'(h);
        it.blit_mode   = mode;
        it.src_pixel   = src;
        return it;
    endfunction

    function automatic blit_item_t read_item(int addr);
        blit_item_t it;
        it = noise_item();
        it.req_type = REQ_READ;
        it.address  = 16'(addr);
        return it;
    endfunction

    function automatic blit_item_t load_item(int addr, logic [7:0] value);
        blit_item_t it;
        it = noise_item();
        it.req_type   = REQ_LOAD;
        it.address    = 16'(addr);
        it.table_data = value;
        return it;
    endfunction

    function automatic logic [7:0] rand_src();
        return ($urandom_range(4) == 0) ? 8'd0 : 8'($urandom);
    endfunction

    task automatic offer(input blit_item_t it);
        req_type    <= it.req_type;
        first_pixel <= it.first_pixel;
        origin_x    <= it.origin_x;
        origin_y    <= it.origin_y;
        sprite_w    <= it.sprite_w;
        sprite_h    <= it.sprite_h;
        blit_mode   <= it.blit_mode;
        src_pixel   <= it.src_pixel;
        address     <= it.address;
        table_data  <= it.table_data;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        shadow.note_item(it);
        if (it.req_type != REQ_NONE)
            items_sent++;
        if ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct)
                @(posedge clk);
        end
    endtask

    // a blend pixel only goes out once its table entry holds a value
    task automatic send_pixel(input blit_item_t it);
        logic [15:0] idx;
        if (shadow.blend_slot(it, idx) && !shadow.blend_loaded[idx])
            offer(load_item(int'(idx), 8'($urandom)));
        offer(it);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (shadow.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic set_draw(input bit on);
        drain();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= on;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        shadow.draw_on = on;
    endtask

    task automatic draw_sprite(input int ox, input int oy, input int w, input int h,
                               input logic [1:0] mode, input int extra);
        for (int n = 0; n < w * h + extra; n++)
            send_pixel(pixel_item(n == 0, ox, oy, w, h, mode, rand_src()));
    endtask

    task automatic probe_sprite(input int ox, input int oy, input int w, input int h);
        int x;
        int y;
        x = ox - ORIGIN_BIAS + int'($urandom_range(0, (w > 0) ? w - 1 : 0));
        y = oy - ORIGIN_BIAS + int'($urandom_range(0, (h > 0) ? h - 1 : 0));
        if (x >= 0 && x < SCREEN_W && y >= 0 && y < SCREEN_H)
            offer(read_item(y * SCREEN_W + x));
        else
            offer(read_item($urandom_range(0, 65535)));
    endtask

    task automatic random_burst();
        int         pick;
        int         ox;
        int         oy;
        int         w;
        int         h;
        int         n;
        logic [1:0] mode;
        blit_item_t it;
        pick = $urandom_range(99);
        if ($urandom_range(9) == 0)
        begin
            ox = int'($urandom_range(0, 2047)) - 1024;
            oy = int'($urandom_range(0, 2047)) - 1024;
        end
        else
        begin
            ox = $urandom_range(0, 360);
            oy = $urandom_range(0, 240);
        end
        w = $urandom_range(1, 12);
        h = $urandom_range(1, 8);
        mode = 2'($urandom);
        if (pick < 65)
        begin
            draw_sprite(ox, oy, w, h, mode, 0);
            repeat ($urandom_range(1, 4))
                probe_sprite(ox, oy, w, h);
        end
        else if (pick < 75)
        begin
            case ($urandom_range(3))
                0: draw_sprite(ox, oy, w, h, mode, $urandom_range(1, 2 * w));
                1:
                    for (n = 0; n < w * h; n++)
                        send_pixel(pixel_item(0, ox, oy, w, h, mode, rand_src()));
                2:
                    for (n = 0; n < w * h; n++)
                        send_pixel(pixel_item(n == 0, ox, oy, $urandom_range(0, 12), h,
                                              mode, rand_src()));
                default:
                    for (n = 0; n < 20; n++)
                        send_pixel(pixel_item(n == 0, ox, oy, 511, 511, mode, rand_src()));
            endcase
            probe_sprite(ox, oy, w, h);
        end
        else if (pick < 85)
        begin
            it = noise_item();
            if (it.req_type == REQ_PIXEL)
                send_pixel(it);
            else
                offer(it);
        end
        else if (pick < 92)
        begin
            repeat ($urandom_range(1, 6))
                offer(load_item($urandom_range(0, 65535), 8'($urandom)));
        end
        else
        begin
            repeat ($urandom_range(1, 6))
                offer(read_item(($urandom_range(3) == 0) ?
                                $urandom_range(FRAME_BYTES, 65535) :
                                $urandom_range(0, FRAME_BYTES - 1)));
        end
    endtask

    initial
    begin : stimulus
        blit_item_t it;
        int         goal;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;

        // cleared screen and out of range reads
        offer(read_item(0));
        offer(read_item(FRAME_BYTES - 1));
        offer(read_item(FRAME_BYTES));
        offer(read_item(65535));
        offer(load_item(16'h0000, 8'h00));
        offer(load_item(16'hFFFF, 8'hFF));
        // each mode on the top left byte, source zero in opaque, key and blend src
        send_pixel(pixel_item(1, 16, 16, 1, 1, MODE_OPAQUE, 8'hFF));
        send_pixel(pixel_item(1, 16, 16, 1, 1, MODE_KEY, 8'h00));
        offer(read_item(0));
        send_pixel(pixel_item(1, 16, 16, 1, 1, MODE_OPAQUE, 8'h00));
        send_pixel(pixel_item(1, 16, 16, 1, 1, MODE_BLEND_SRC, 8'h80));
        offer(read_item(0));
        send_pixel(pixel_item(1, 16, 16, 1, 1, MODE_BLEND_DST, 8'h3C));
        send_pixel(pixel_item(1, 16, 16, 1, 1, MODE_BLEND_SRC, 8'h00));
        send_pixel(pixel_item(1, 16, 16, 1, 1, MODE_KEY, 8'hAA));
        offer(read_item(0));
        // bottom right corner, far off screen, straddling the left edge
        send_pixel(pixel_item(1, 335, 215, 1, 1, MODE_OPAQUE, 8'h5A));
        offer(read_item(FRAME_BYTES - 1));
        send_pixel(pixel_item(1, -1024, -1024, 511, 511, MODE_OPAQUE, 8'h77));
        send_pixel(pixel_item(1, 1023, 1023, 511, 511, MODE_OPAQUE, 8'h77));
        draw_sprite(15, 16, 2, 1, MODE_OPAQUE, 0);
        offer(read_item(0));
        // zero size and rows past the end of the sprite are dropped
        send_pixel(pixel_item(1, 16, 16, 0, 1, MODE_OPAQUE, 8'h11));
        send_pixel(pixel_item(1, 16, 16, 1, 0, MODE_OPAQUE, 8'h22));
        draw_sprite(16, 17, 1, 1, MODE_OPAQUE, 1);
        offer(read_item(0));
        offer(read_item(SCREEN_W));
        offer(read_item(2 * SCREEN_W));
        it = noise_item();
        it.req_type = REQ_NONE;
        offer(it);

        for (int ph = 0; ph < 4; ph++)
        begin
            tx_idle_pct  = (ph == 1) ? 53 : (ph == 3) ? 20 : 0;
            rx_stall_pct = (ph == 2) ? 53 : (ph == 3) ? 20 : 0;
            set_draw(ph != 1);
            if (ph == 0)
            begin
                // stall the output long enough to back up the whole pipe
                start_hold = 1'b1;
                repeat (40)
                begin
                    if ($urandom_range(3) == 0)
                        draw_sprite($urandom_range(0, 360), $urandom_range(0, 240),
                                    2, 2, 2'($urandom), 0);
                    else
                        offer(read_item($urandom_range(0, 65535)));
                end
                drain();
            end
            goal = items_sent + ITEM_TARGET / 8;
            while (items_sent < goal)
                random_burst();
            if (ph == 1)
                set_draw(1'b1);
            goal = (ph + 1) * ITEM_TARGET / 4;
            while (items_sent < goal)
                random_burst();
        end

        drain();
        $display("%0d items sent over four idle/stall phases with draw enable on and off",
                 items_sent);
        $display("%0d reads checked, %0d pixels written", shadow.checked, shadow.landed);
        if (shadow.pending() != 0)
            $display("%0.1f ns: %0d reads expected, none arrived", $realtime, shadow.pending());
        if (shadow.errors == 0 && shadow.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
